[rtl/bbi_pkg.sv]
// ----------------------------------------------------------------------------
// bbi_pkg
// Shared types, constants and a helper for the four-row byte block interleaver.
// ----------------------------------------------------------------------------
package bbi_pkg;

    localparam int WORD_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int ROW_COUNT = 4;
    localparam int CNT_W     = 7;   // code_len width, holds block sizes up to 64
    localparam int REG_IDX_W = 2;

    // configuration register indexes
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    localparam reg_idx_t REG_CODE_LEN  = 2'd0;
    localparam reg_idx_t REG_PAD_VALUE = 2'd1;
    localparam reg_idx_t REG_DIRECTION = 2'd2;

    localparam logic [CNT_W-1:0] CODE_LEN_RESET = 7'd64;

    // one closed block handed from the front to the back
    typedef struct packed {
        logic             buf_sel;  // ping-pong half holding the block
        logic [CNT_W-1:0] len;      // words actually written
        logic             last;     // block closed by the end of the stream
        logic             err;      // deinterleave stream ended mid-block
    } desc_t;

    // one result beat
    typedef struct packed {
        logic [WORD_W-1:0] out_word;
        logic              run_last;
        logic              stream_done;
        logic              length_error;
    } res_t;

    // block size: code length clamped to at least one, rounded up to four,
    // capped at the largest multiple of four that fits the store
    function automatic logic [CNT_W-1:0] blk_words(input logic [CNT_W-1:0] code_len,
                                                   input logic [CNT_W:0]   max_words);
        logic [CNT_W:0] c;
        logic [CNT_W:0] r4;
        c  = (code_len == '0) ? (CNT_W+1)'(1) : {1'b0, code_len};
        r4 = (c + (CNT_W+1)'(3)) & ~(CNT_W+1)'(3);
        if (r4 > max_words)
            r4 = max_words;
        return r4[CNT_W-1:0];
    endfunction

endpackage

[rtl/bbi_if.sv]
// ----------------------------------------------------------------------------
// bbi channel interfaces
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface bbi_in_if import bbi_pkg::*;;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data_word;
    logic              stream_last;

    modport source (output valid, data_word, stream_last, input ready);
    modport sink   (input valid, data_word, stream_last, output ready);
endinterface

interface bbi_out_if import bbi_pkg::*;;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] out_word;
    logic              run_last;
    logic              stream_done;
    logic              length_error;

    modport source (output valid, out_word, run_last, stream_done, length_error,
                    input ready);
    modport sink   (input valid, out_word, run_last, stream_done, length_error,
                    output ready);
endinterface

[rtl/bbi_store.sv]
// ----------------------------------------------------------------------------
// bbi_store
// Four word-wide banks, each split into two ping-pong halves. One write and
// one common read address per cycle, read data registered.
// ----------------------------------------------------------------------------
module bbi_store import bbi_pkg::*;
#(
    parameter int  MAX_BLOCK_WORDS = 64,
    localparam int BANK_WORDS      = MAX_BLOCK_WORDS / ROW_COUNT,
    localparam int AW              = (BANK_WORDS > 1) ? $clog2(BANK_WORDS) : 1
)
(
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [1:0]                      wr_bank,
    input  logic [AW:0]                     wr_addr,
    input  logic [WORD_W-1:0]               wr_data,
    input  logic                            rd_en,
    input  logic [AW:0]                     rd_addr,
    output logic [ROW_COUNT-1:0][WORD_W-1:0] rd_data
);

    localparam int DEPTH = 2 << AW;

    for (genvar g = 0; g < ROW_COUNT; g++) begin : g_bank
        logic [WORD_W-1:0] mem [0:DEPTH-1];

        // bank write
        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_bank == 2'(g)))
                mem[wr_addr] <= wr_data;
        end

        // registered read
        always_ff @(posedge clk)
        begin
            if (rd_en)
                rd_data[g] <= mem[rd_addr];
        end
    end

endmodule

[rtl/bbi_front.sv]
// ----------------------------------------------------------------------------
// bbi_front
// Takes input beats, places each word in the store and closes blocks into
// descriptors for the back end.
// ----------------------------------------------------------------------------
module bbi_front import bbi_pkg::*;
#(
    parameter int  MAX_BLOCK_WORDS = 64,
    localparam int BANK_WORDS      = MAX_BLOCK_WORDS / ROW_COUNT,
    localparam int AW              = (BANK_WORDS > 1) ? $clog2(BANK_WORDS) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    bbi_in_if.sink            data_ch,
    input  logic [CNT_W-1:0]  blk_size,
    input  logic              direction,
    input  logic              cfg_clear,
    input  logic              q_full,
    output logic              push,
    output desc_t             push_desc,
    output logic              wr_en,
    output logic [1:0]        wr_bank,
    output logic [AW:0]       wr_addr,
    output logic [WORD_W-1:0] wr_data
);

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [1:0]       row_reg, row_next;
    logic [AW-1:0]    off_reg, off_next;
    logic             buf_reg, buf_next;

    logic             accept;
    logic [CNT_W-1:0] fill_inc;
    logic [CNT_W-1:0] row_words;
    logic             close;

    assign data_ch.ready = !q_full;
    assign accept        = data_ch.valid && data_ch.ready;
    assign fill_inc      = fill_reg + CNT_W'(1);
    assign row_words     = blk_size >> 2;
    assign close         = (fill_inc == blk_size) || data_ch.stream_last;

    // store placement: rows per bank on interleave, word mod four on deinterleave
    assign wr_en   = accept;
    assign wr_bank = direction ? fill_reg[1:0] : row_reg;
    assign wr_addr = {buf_reg, direction ? fill_reg[AW+1:2] : off_reg};
    assign wr_data = data_ch.data_word;

    // descriptor for a closed block
    assign push              = accept && close;
    assign push_desc.buf_sel = buf_reg;
    assign push_desc.len     = fill_inc;
    assign push_desc.last    = data_ch.stream_last;
    assign push_desc.err     = direction && (fill_inc != blk_size);

    // fill and row position tracking
    always_comb
    begin
        fill_next = fill_reg;
        row_next  = row_reg;
        off_next  = off_reg;
        buf_next  = buf_reg;
        if (cfg_clear) begin
            fill_next = '0;
            row_next  = '0;
            off_next  = '0;
        end
        else if (accept) begin
            if (close) begin
                fill_next = '0;
                row_next  = '0;
                off_next  = '0;
                buf_next  = !buf_reg;
            end
            else begin
                fill_next = fill_inc;
                if ((CNT_W'(off_reg) + CNT_W'(1)) == row_words) begin
                    off_next = '0;
                    row_next = row_reg + 2'd1;
                end
                else begin
                    off_next = off_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_reg <= '0;
            row_reg  <= '0;
            off_reg  <= '0;
            buf_reg  <= 1'b0;
        end
        else begin
            fill_reg <= fill_next;
            row_reg  <= row_next;
            off_reg  <= off_next;
            buf_reg  <= buf_next;
        end
    end

endmodule

[rtl/bbi_desc_q.sv]
// ----------------------------------------------------------------------------
// bbi_desc_q
// Two-entry queue of closed block descriptors, one per ping-pong half.
// ----------------------------------------------------------------------------
module bbi_desc_q import bbi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output desc_t head
);

    desc_t      slot_reg [0:1];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = slot_reg[rp_reg];

    // pointer and count update
    always_comb
    begin
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = pop  ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // descriptor storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= push_desc;
    end

endmodule

[rtl/bbi_back.sv]
// ----------------------------------------------------------------------------
// bbi_back
// Walks a closed block one result per cycle while the result queue has room:
// reads the banks, takes a byte from each, pads and queues the result beat.
// ----------------------------------------------------------------------------
module bbi_back import bbi_pkg::*;
#(
    parameter int  MAX_BLOCK_WORDS = 64,
    localparam int BANK_WORDS      = MAX_BLOCK_WORDS / ROW_COUNT,
    localparam int AW              = (BANK_WORDS > 1) ? $clog2(BANK_WORDS) : 1
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [CNT_W-1:0]                 blk_size,
    input  logic                             direction,
    input  logic [WORD_W-1:0]                pad_value,
    input  logic                             head_valid,
    input  desc_t                            head,
    output logic                             pop,
    output logic                             rd_en,
    output logic [AW:0]                      rd_addr,
    input  logic [ROW_COUNT-1:0][WORD_W-1:0] rd_data,
    bbi_out_if.source                        result_ch
);

    localparam int OQ_DEPTH = 4;

    // walk counters
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [AW-1:0]        jq_reg, jq_next;
    logic [1:0]           rr_reg, rr_next;

    // read stage
    logic                 s1_valid_reg;
    logic                 s1_err_reg;
    logic [1:0]           s1_sel_reg;
    logic [ROW_COUNT-1:0] s1_pad_reg;
    logic                 s1_rl_reg;
    logic                 s1_sd_reg;

    // result queue
    res_t                 oq_reg [0:OQ_DEPTH-1];
    logic [1:0]           oq_wp_reg, oq_rp_reg;
    logic [2:0]           oq_cnt_reg, oq_cnt_next;

    logic [CNT_W-1:0]     row_words;
    logic                 room;
    logic                 issue;
    logic                 k_last;
    logic                 blk_end;
    logic [1:0]           sel;
    logic [ROW_COUNT-1:0] pad_mask;
    logic [CNT_W:0]       row_base;
    res_t                 s1_res;
    logic                 oq_pop;

    assign row_words = blk_size >> 2;
    assign room      = (4'(oq_cnt_reg) + 4'(s1_valid_reg)) < 4'(OQ_DEPTH);
    assign issue     = head_valid && room;
    assign k_last    = ((k_reg + CNT_W'(1)) == blk_size);
    assign blk_end   = head.err || k_last;
    assign pop       = issue && blk_end;

    // bank read address and byte lane
    assign rd_en   = issue && !head.err;
    assign rd_addr = {head.buf_sel, direction ? jq_reg : k_reg[AW+1:2]};
    assign sel     = direction ? rr_reg : k_reg[1:0];

    // words past the written length read as the pad word on interleave
    always_comb
    begin
        row_base = '0;
        for (int r = 0; r < ROW_COUNT; r++) begin
            pad_mask[r] = !direction &&
                          ((row_base + (CNT_W+1)'(k_reg >> 2)) >= (CNT_W+1)'(head.len));
            row_base    = row_base + (CNT_W+1)'(row_words);
        end
    end

    // walk position
    always_comb
    begin
        k_next  = k_reg;
        jq_next = jq_reg;
        rr_next = rr_reg;
        if (issue) begin
            if (blk_end) begin
                k_next  = '0;
                jq_next = '0;
                rr_next = '0;
            end
            else begin
                k_next = k_reg + CNT_W'(1);
                if ((CNT_W'(jq_reg) + CNT_W'(1)) == row_words) begin
                    jq_next = '0;
                    rr_next = rr_reg + 2'd1;
                end
                else begin
                    jq_next = jq_reg + AW'(1);
                end
            end
        end
    end

    // gather one byte lane from each bank
    always_comb
    begin
        s1_res.run_last     = s1_err_reg || s1_rl_reg;
        s1_res.stream_done  = s1_err_reg || s1_sd_reg;
        s1_res.length_error = s1_err_reg;
        s1_res.out_word     = '0;
        if (!s1_err_reg) begin
            for (int i = 0; i < ROW_COUNT; i++) begin
                s1_res.out_word[i*BYTE_W +: BYTE_W] = s1_pad_reg[i] ?
                    pad_value[{s1_sel_reg, 3'b000} +: BYTE_W] :
                    rd_data[i][{s1_sel_reg, 3'b000} +: BYTE_W];
            end
        end
    end

    // result queue output side
    assign oq_pop                 = result_ch.valid && result_ch.ready;
    assign result_ch.valid        = (oq_cnt_reg != 3'd0);
    assign result_ch.out_word     = oq_reg[oq_rp_reg].out_word;
    assign result_ch.run_last     = oq_reg[oq_rp_reg].run_last;
    assign result_ch.stream_done  = oq_reg[oq_rp_reg].stream_done;
    assign result_ch.length_error = oq_reg[oq_rp_reg].length_error;
    assign oq_cnt_next            = oq_cnt_reg + 3'(s1_valid_reg) - 3'(oq_pop);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            k_reg        <= '0;
            jq_reg       <= '0;
            rr_reg       <= '0;
            s1_valid_reg <= 1'b0;
            oq_wp_reg    <= '0;
            oq_rp_reg    <= '0;
            oq_cnt_reg   <= '0;
        end
        else begin
            k_reg        <= k_next;
            jq_reg       <= jq_next;
            rr_reg       <= rr_next;
            s1_valid_reg <= issue;
            if (s1_valid_reg)
                oq_wp_reg <= oq_wp_reg + 2'd1;
            if (oq_pop)
                oq_rp_reg <= oq_rp_reg + 2'd1;
            oq_cnt_reg   <= oq_cnt_next;
        end
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (issue) begin
            s1_err_reg <= head.err;
            s1_sel_reg <= sel;
            s1_pad_reg <= pad_mask;
            s1_rl_reg  <= k_last;
            s1_sd_reg  <= k_last && head.last;
        end
        if (s1_valid_reg)
            oq_reg[oq_wp_reg] <= s1_res;
    end

endmodule

[rtl/byte_block_interleaver.sv]
// ----------------------------------------------------------------------------
// byte_block_interleaver
// Four-row byte block interleaver and deinterleaver over 32-bit words.
//
//   channel     dir  beat contents
//   ----------  ---  ---------------------------------------------------
//   data_ch     in   data_word, stream_last
//   result_ch   out  out_word, run_last, stream_done, length_error
//   cfg_*       in   register write: code_len, pad_value, direction
//
// The front takes one word per cycle into one half of a ping-pong store while
// the descriptor queue has room; the back reads the other half and emits one
// result per cycle while its result queue has room, overlapped across blocks.
// With the back end idle, the first result of a block goes from its closing beat
// through the descriptor queue, the bank read and the result queue registers.
// The front stalls only while both store halves hold unfinished blocks.
// Reset clears all control state; the store itself is not cleared.
// ----------------------------------------------------------------------------
module byte_block_interleaver import bbi_pkg::*;
#(
    parameter int MAX_BLOCK_WORDS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    bbi_in_if.sink               data_ch,
    bbi_out_if.source            result_ch
);

    localparam int BANK_WORDS = MAX_BLOCK_WORDS / ROW_COUNT;
    localparam int AW         = (BANK_WORDS > 1) ? $clog2(BANK_WORDS) : 1;
    localparam logic [CNT_W:0] MAX_SIZE = (CNT_W+1)'(BANK_WORDS * ROW_COUNT);

    logic [CNT_W-1:0]  code_len_reg;
    logic [WORD_W-1:0] pad_value_reg;
    logic              direction_reg;

    logic              cfg_clear;
    logic [CNT_W-1:0]  blk_size;

    logic              push;
    desc_t             push_desc;
    logic              q_full;
    logic              head_valid;
    desc_t             head;
    logic              pop;

    logic                             wr_en;
    logic [1:0]                       wr_bank;
    logic [AW:0]                      wr_addr;
    logic [WORD_W-1:0]                wr_data;
    logic                             rd_en;
    logic [AW:0]                      rd_addr;
    logic [ROW_COUNT-1:0][WORD_W-1:0] rd_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            code_len_reg  <= CODE_LEN_RESET;
            pad_value_reg <= '0;
            direction_reg <= 1'b0;
        end
        else if (cfg_we) begin
            case (cfg_index)
                REG_CODE_LEN:  code_len_reg  <= cfg_data[CNT_W-1:0];
                REG_PAD_VALUE: pad_value_reg <= cfg_data;
                REG_DIRECTION: direction_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // a size or direction change drops any partial block
    assign cfg_clear = cfg_we && ((cfg_index == REG_CODE_LEN) ||
                                  (cfg_index == REG_DIRECTION));
    assign blk_size  = blk_words(code_len_reg, MAX_SIZE);

    bbi_front #(.MAX_BLOCK_WORDS(MAX_BLOCK_WORDS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_ch   (data_ch),
        .blk_size  (blk_size),
        .direction (direction_reg),
        .cfg_clear (cfg_clear),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc),
        .wr_en     (wr_en),
        .wr_bank   (wr_bank),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    bbi_desc_q u_desc_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    bbi_store #(.MAX_BLOCK_WORDS(MAX_BLOCK_WORDS)) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_bank (wr_bank),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bbi_back #(.MAX_BLOCK_WORDS(MAX_BLOCK_WORDS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .blk_size   (blk_size),
        .direction  (direction_reg),
        .pad_value  (pad_value_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .result_ch  (result_ch)
    );

    // a block never closes into a full descriptor queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("descriptor pushed while queue full");

    // the back end only retires a block that is present
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("descriptor popped from empty queue");

    // an error beat is a lone zero word that ends the stream
    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (result_ch.valid && result_ch.length_error) |->
            (result_ch.out_word == '0) && result_ch.run_last && result_ch.stream_done)
        else $error("malformed length error beat");

endmodule
